// File: rtl/hcb_pkg.sv
// Package: shared types and constants of the Huffman code builder.
`timescale 1ns / 1ps

package hcb_pkg;

    localparam int MAX_LEAVES_DEF  = 32;
    localparam int WEIGHT_BITS_DEF = 16;
    localparam int LETTERS         = 26;
    localparam int SYM_W           = 8;
    localparam int ITEM_WEIGHT_W   = 16;
    localparam int CODE_W          = 32;
    localparam int CODE_LEN_W      = 5;
    localparam int LETTER_IDX_W    = 5;
    localparam logic [SYM_W-1:0] CHAR_A = 8'h61;
    localparam logic [SYM_W-1:0] CHAR_Z = 8'h7a;
    localparam logic [LETTER_IDX_W-1:0] LAST_LETTER = LETTER_IDX_W'(LETTERS - 1);

    // Input transaction
    typedef struct packed {
        logic [SYM_W-1:0]         symbol;
        logic [ITEM_WEIGHT_W-1:0] leaf_weight;
        logic                     last;
    } t_item;

    // Result transaction
    typedef struct packed {
        logic [SYM_W-1:0]      leaf_symbol;
        logic [CODE_W-1:0]     code_bits;
        logic [CODE_LEN_W-1:0] code_length;
        logic                  no_leaves;
        logic                  overflowed;
        logic                  final_code;
    } t_result;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic gather_step;
        logic build_init;
        logic scan_step;
        logic merge_a;
        logic merge_b;
        logic leaf_start;
        logic walk_rd;
        logic walk_adv;
        logic emit_leaf;
        logic emit_empty;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic mode;
        logic gather_done;
        logic leaf_zero;
        logic single_leaf;
        logic scan_done;
        logic build_last;
        logic node_linked;
        logic last_leaf;
    } t_status;

endpackage

// File: rtl/hcb_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module hcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/hcb_ctrl.sv
// Controller: sequences load, letter gather, tree build and code walk.
`timescale 1ns / 1ps

module hcb_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_last,
    input  hcb_pkg::t_status i_status,
    output hcb_pkg::t_cmd    o_cmd,
    output logic            o_busy
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_GATHER  = 4'd1;
    localparam logic [3:0] ST_CHECK   = 4'd2;
    localparam logic [3:0] ST_EMPTY   = 4'd3;
    localparam logic [3:0] ST_SCAN    = 4'd4;
    localparam logic [3:0] ST_MERGE_A = 4'd5;
    localparam logic [3:0] ST_MERGE_B = 4'd6;
    localparam logic [3:0] ST_LEAF    = 4'd7;
    localparam logic [3:0] ST_WALK    = 4'd8;
    localparam logic [3:0] ST_WAIT    = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_last) begin
                        n_state = i_status.mode ? ST_CHECK : ST_GATHER;
                    end
                end
            end
            ST_GATHER: begin
                o_cmd.gather_step = 1'b1;
                if (i_status.gather_done) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_status.leaf_zero) begin
                    n_state = ST_EMPTY;
                end else begin
                    o_cmd.build_init = 1'b1;
                    n_state = i_status.single_leaf ? ST_LEAF : ST_SCAN;
                end
            end
            ST_EMPTY: begin
                o_cmd.emit_empty = 1'b1;
                n_state = ST_IDLE;
            end
            ST_SCAN: begin
                if (i_status.scan_done) begin
                    n_state = ST_MERGE_A;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            ST_MERGE_A: begin
                o_cmd.merge_a = 1'b1;
                n_state = ST_MERGE_B;
            end
            ST_MERGE_B: begin
                o_cmd.merge_b = 1'b1;
                n_state = i_status.build_last ? ST_LEAF : ST_SCAN;
            end
            ST_LEAF: begin
                o_cmd.leaf_start = 1'b1;
                n_state = ST_WALK;
            end
            ST_WALK: begin
                if (i_status.node_linked) begin
                    o_cmd.walk_rd = 1'b1;
                    n_state = ST_WAIT;
                end else begin
                    o_cmd.emit_leaf = 1'b1;
                    n_state = i_status.last_leaf ? ST_IDLE : ST_LEAF;
                end
            end
            ST_WAIT: begin
                o_cmd.walk_adv = 1'b1;
                n_state = ST_WALK;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

// File: rtl/hcb_datapath.sv
// Datapath: letter counters, node memories, min scan and code walk.
`timescale 1ns / 1ps

module hcb_datapath #(
    parameter int MAX_LEAVES  = hcb_pkg::MAX_LEAVES_DEF,
    parameter int WEIGHT_BITS = hcb_pkg::WEIGHT_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata,
    input  hcb_pkg::t_item   i_item,
    input  hcb_pkg::t_cmd    i_cmd,
    output hcb_pkg::t_status o_status,
    output logic             o_result_valid,
    output hcb_pkg::t_result o_result
);

    localparam int NODES     = 2 * MAX_LEAVES - 1;
    localparam int NODE_BITS = $clog2(NODES);
    localparam int LEAF_BITS = $clog2(MAX_LEAVES);
    localparam int WSUM_W    = WEIGHT_BITS + $clog2(MAX_LEAVES);
    localparam int LEN_W     = NODE_BITS + 5;

    localparam logic [NODE_BITS-1:0] MAX_CNT = NODE_BITS'(MAX_LEAVES);

    logic                     r_mode;
    logic [WEIGHT_BITS-1:0]   r_counts [hcb_pkg::LETTERS];
    logic [hcb_pkg::LETTER_IDX_W-1:0] r_letter_idx;
    logic [NODE_BITS-1:0]     r_leaf_count;
    logic                     r_drop;
    logic [NODE_BITS-1:0]     r_k;
    logic [NODE_BITS-1:0]     r_scan_idx;
    logic [NODE_BITS-1:0]     r_scan_addr;
    logic                     r_scan_vld;
    logic                     r_have1;
    logic                     r_have2;
    logic [WSUM_W-1:0]        r_w1;
    logic [WSUM_W-1:0]        r_w2;
    logic [NODE_BITS-1:0]     r_i1;
    logic [NODE_BITS-1:0]     r_i2;
    logic [NODES-1:0]         r_linked;
    logic [NODES-1:0]         r_right;
    logic [LEAF_BITS-1:0]     r_leaf_idx;
    logic [NODE_BITS-1:0]     r_node;
    logic [LEN_W-1:0]         r_len;
    logic [hcb_pkg::CODE_W-1:0] r_code;
    logic                     r_result_vld;
    hcb_pkg::t_result         r_result;

    logic [hcb_pkg::SYM_W-1:0] sym_off;
    logic                      is_letter;
    logic [hcb_pkg::LETTER_IDX_W-1:0] cnt_addr;
    logic [WEIGHT_BITS-1:0]    cnt;
    logic                      has_room;
    logic                      load_leaf;
    logic                      gather_leaf;
    logic                      clear_run;
    logic                      scan_issue;
    logic [WEIGHT_BITS+hcb_pkg::ITEM_WEIGHT_W-1:0] item_w_ext;
    logic [WSUM_W-1:0]         item_w;
    logic [WSUM_W-1:0]         w_rdata;
    logic [NODE_BITS-1:0]      p_rdata;
    logic [hcb_pkg::SYM_W-1:0] s_rdata;
    logic                      w_we;
    logic [NODE_BITS-1:0]      w_waddr;
    logic [WSUM_W-1:0]         w_wdata;
    logic                      s_we;
    logic [hcb_pkg::SYM_W-1:0] s_wdata;
    logic                      p_we;
    logic [NODE_BITS-1:0]      p_waddr;
    logic [NODE_BITS:0]        two_l_m1;
    logic [NODE_BITS:0]        k_p1;

    // Input decode and letter counter read port
    assign sym_off    = i_item.symbol - hcb_pkg::CHAR_A;
    assign is_letter  = (i_item.symbol >= hcb_pkg::CHAR_A) && (i_item.symbol <= hcb_pkg::CHAR_Z);
    assign cnt_addr   = i_cmd.gather_step ? r_letter_idx : sym_off[hcb_pkg::LETTER_IDX_W-1:0];
    assign cnt        = r_counts[cnt_addr];
    assign item_w_ext = {{WEIGHT_BITS{1'b0}}, i_item.leaf_weight};
    assign item_w     = WSUM_W'(item_w_ext[WEIGHT_BITS-1:0]);

    assign has_room    = (r_leaf_count < MAX_CNT);
    assign load_leaf   = i_cmd.load && r_mode && has_room;
    assign gather_leaf = i_cmd.gather_step && (cnt != '0) && has_room;
    assign clear_run   = i_cmd.emit_empty || (i_cmd.emit_leaf && o_status.last_leaf);
    assign scan_issue  = i_cmd.scan_step && (r_scan_idx < r_k);

    // Memory write ports
    always_comb begin
        w_we    = load_leaf || gather_leaf || i_cmd.merge_a;
        w_waddr = i_cmd.merge_a ? r_k : r_leaf_count;
        w_wdata = item_w;
        if (i_cmd.merge_a) begin
            w_wdata = r_w1 + r_w2;
        end else if (i_cmd.gather_step) begin
            w_wdata = WSUM_W'(cnt);
        end
        s_we    = load_leaf || gather_leaf;
        s_wdata = i_cmd.gather_step ? (hcb_pkg::CHAR_A + hcb_pkg::SYM_W'(r_letter_idx))
                                    : i_item.symbol;
        p_we    = i_cmd.merge_a || i_cmd.merge_b;
        p_waddr = i_cmd.merge_a ? r_i1 : r_i2;
    end

    hcb_ram #(.WIDTH(WSUM_W), .DEPTH(NODES)) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (scan_issue),
        .i_raddr (r_scan_idx),
        .o_rdata (w_rdata)
    );

    hcb_ram #(.WIDTH(hcb_pkg::SYM_W), .DEPTH(MAX_LEAVES)) u_symbol_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (r_leaf_count[LEAF_BITS-1:0]),
        .i_wdata (s_wdata),
        .i_re    (i_cmd.leaf_start),
        .i_raddr (r_leaf_idx),
        .o_rdata (s_rdata)
    );

    hcb_ram #(.WIDTH(NODE_BITS), .DEPTH(NODES)) u_parent_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (r_k),
        .i_re    (i_cmd.walk_rd),
        .i_raddr (r_node),
        .o_rdata (p_rdata)
    );

    // Mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    // Letter counters, saturating
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clear_run) begin
            r_counts <= '{default: '0};
        end else if (i_cmd.load && !r_mode && is_letter && (cnt != '1)) begin
            r_counts[cnt_addr] <= cnt + 1'b1;
        end
    end

    // Leaf count, overflow flag, gather index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clear_run) begin
            r_leaf_count <= '0;
            r_drop       <= 1'b0;
            r_letter_idx <= '0;
        end else if (i_cmd.load) begin
            if (r_mode) begin
                if (has_room) begin
                    r_leaf_count <= r_leaf_count + 1'b1;
                end else begin
                    r_drop <= 1'b1;
                end
            end else if (i_item.last) begin
                r_leaf_count <= '0;
                r_letter_idx <= '0;
            end
        end else if (i_cmd.gather_step) begin
            r_letter_idx <= r_letter_idx + 1'b1;
            if (cnt != '0) begin
                if (has_room) begin
                    r_leaf_count <= r_leaf_count + 1'b1;
                end else begin
                    r_drop <= 1'b1;
                end
            end
        end
    end

    // Two-minimum scan over parentless nodes, lowest index wins ties
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_vld <= 1'b0;
            r_have1    <= 1'b0;
            r_have2    <= 1'b0;
            r_scan_idx <= '0;
            r_k        <= '0;
        end else if (i_cmd.build_init || i_cmd.merge_b) begin
            r_scan_vld <= 1'b0;
            r_have1    <= 1'b0;
            r_have2    <= 1'b0;
            r_scan_idx <= '0;
            r_k        <= i_cmd.build_init ? r_leaf_count : r_k + 1'b1;
        end else begin
            r_scan_vld <= scan_issue;
            if (scan_issue) begin
                r_scan_idx <= r_scan_idx + 1'b1;
            end
            if (r_scan_vld && !r_linked[r_scan_addr]) begin
                if (!r_have1 || (w_rdata < r_w1)) begin
                    r_have2 <= r_have1;
                    r_w2    <= r_w1;
                    r_i2    <= r_i1;
                    r_have1 <= 1'b1;
                    r_w1    <= w_rdata;
                    r_i1    <= r_scan_addr;
                end else if (!r_have2 || (w_rdata < r_w2)) begin
                    r_have2 <= 1'b1;
                    r_w2    <= w_rdata;
                    r_i2    <= r_scan_addr;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan_addr <= r_scan_idx;
    end

    // Per-node linked and right-child bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.build_init) begin
            r_linked <= '0;
            r_right  <= '0;
        end else if (i_cmd.merge_a) begin
            r_linked <= r_linked | (NODES'(1) << r_i1) | (NODES'(1) << r_i2);
            r_right  <= r_right | (NODES'(1) << r_i2);
        end
    end

    // Code walk from leaf to root
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leaf_idx <= '0;
        end else if (i_cmd.build_init) begin
            r_leaf_idx <= '0;
        end else if (i_cmd.emit_leaf) begin
            r_leaf_idx <= r_leaf_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.leaf_start) begin
            r_node <= NODE_BITS'(r_leaf_idx);
            r_len  <= '0;
            r_code <= '0;
        end else if (i_cmd.walk_rd) begin
            r_len <= r_len + 1'b1;
            if (r_right[r_node] && (r_len < LEN_W'(hcb_pkg::CODE_W))) begin
                r_code[r_len[hcb_pkg::CODE_LEN_W-1:0]] <= 1'b1;
            end
        end else if (i_cmd.walk_adv) begin
            r_node <= p_rdata;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result_vld <= 1'b0;
        end else begin
            r_result_vld <= i_cmd.emit_leaf || i_cmd.emit_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_empty) begin
            r_result <= '{leaf_symbol: '0, code_bits: '0, code_length: '0,
                          no_leaves: 1'b1, overflowed: 1'b0, final_code: 1'b1};
        end else if (i_cmd.emit_leaf) begin
            r_result <= '{leaf_symbol: s_rdata, code_bits: r_code,
                          code_length: r_len[hcb_pkg::CODE_LEN_W-1:0],
                          no_leaves: 1'b0, overflowed: r_drop,
                          final_code: o_status.last_leaf};
        end
    end

    // Status
    assign two_l_m1 = {r_leaf_count, 1'b0} - 1'b1;
    assign k_p1     = {1'b0, r_k} + 1'b1;

    always_comb begin
        o_status.mode        = r_mode;
        o_status.gather_done = (r_letter_idx == hcb_pkg::LAST_LETTER);
        o_status.leaf_zero   = (r_leaf_count == '0);
        o_status.single_leaf = (r_leaf_count == NODE_BITS'(1));
        o_status.scan_done   = (r_scan_idx == r_k) && !r_scan_vld;
        o_status.build_last  = (k_p1 == two_l_m1);
        o_status.node_linked = r_linked[r_node];
        o_status.last_leaf   = (NODE_BITS'(r_leaf_idx) == (r_leaf_count - 1'b1));
    end

    assign o_result_valid = r_result_vld;
    assign o_result       = r_result;

`ifndef NO_ASSERTIONS
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_result_vld |=> !r_result_vld)
        else $error("result strobe held for more than one cycle");

    a_merge_has_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.merge_a |-> (r_have1 && r_have2 && (r_i1 != r_i2)))
        else $error("merge without two distinct parentless nodes");

    a_leaf_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_leaf_count <= MAX_CNT)
        else $error("leaf count beyond capacity");

    a_empty_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_empty |-> (r_leaf_count == '0))
        else $error("empty result with leaves held");

    a_clear_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_leaf && o_status.last_leaf) |=> (r_leaf_count == '0) && !r_drop)
        else $error("run state not cleared after final result");
`endif

endmodule

// File: rtl/huffman_code_builder_core.sv
// Top level: Huffman code builder core, controller plus datapath.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                         Payload
// item      in         start && !busy                    i_item (t_item)
// result    out        o_result_valid, one cycle each    o_result (t_result)
// config    in         i_cfg_we, no wait                 i_cfg_wdata (weight_source)
//
// Loading accepts one item per cycle while busy is low. After the item marked last,
// letter mode gathers the letter counts, then the CHECK state runs; each of the L-1
// merges then scans the parentless nodes and writes in the MERGE_A and MERGE_B states.
// Each leaf code is then walked from leaf to root, one parent memory read per tree level.
// busy rises after the last item and falls as the final result strobe goes out;
// results cannot be stalled. Reset is synchronous and clears control state and counts.

module huffman_code_builder_core #(
    parameter int MAX_LEAVES  = hcb_pkg::MAX_LEAVES_DEF,
    parameter int WEIGHT_BITS = hcb_pkg::WEIGHT_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata,
    input  logic             start,
    output logic             busy,
    input  hcb_pkg::t_item   i_item,
    output logic             o_result_valid,
    output hcb_pkg::t_result o_result
);

    hcb_pkg::t_cmd    cmd;
    hcb_pkg::t_status status;

    hcb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_last   (i_item.last),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    hcb_datapath #(
        .MAX_LEAVES  (MAX_LEAVES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_item         (i_item),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule

// File: verif/tb_top.sv
// Testbench for the Huffman code builder core: directed and random load runs checked against a tree model.
`timescale 1ns / 1ps

module tb_top;

    localparam int NLEAF = hcb_pkg::MAX_LEAVES_DEF;
    localparam int NNODE = 2 * NLEAF - 1;
    localparam int WDOG_LIMIT = 20000;
    localparam logic MODE_LETTERS = 1'b0;
    localparam logic MODE_PAIRS   = 1'b1;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_cfg_we;
    logic     i_cfg_wdata;
    logic     start;
    logic     busy;
    hcb_pkg::t_item   i_item;
    logic     o_result_valid;
    hcb_pkg::t_result o_result;

    huffman_code_builder_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .start(start), .busy(busy), .i_item(i_item),
        .o_result_valid(o_result_valid), .o_result(o_result)
    );

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    // Predictor state
    logic             cur_mode;
    logic [15:0]      letter_cnt [hcb_pkg::LETTERS];
    logic [7:0]       leaf_sym [NLEAF];
    logic [21:0]      node_w [NNODE];
    int               node_up [NNODE];
    int               node_left [NNODE];
    bit               node_used [NNODE];
    int               n_leaves;
    bit               dropped;

    hcb_pkg::t_result code_q [$];
    hcb_pkg::t_item   item_q [$];
    int               mismatches;
    bit               failed;
    int               idle_cycles;

    task automatic clear_run();
        for (int i = 0; i < hcb_pkg::LETTERS; i++) letter_cnt[i] = '0;
        n_leaves = 0;
        dropped  = 0;
    endtask

    function automatic int lightest(int limit, int skip);
        int best;
        bit found;
        best = 0;
        found = 0;
        for (int i = 0; i < limit; i++) begin
            if (node_used[i] || i == skip) continue;
            if (!found || node_w[i] < node_w[best]) begin
                best = i;
                found = 1;
            end
        end
        return best;
    endfunction

    // Apply one accepted transaction to the predictor
    task automatic predict_codes(hcb_pkg::t_item it);
        hcb_pkg::t_result r;
        int a, b, nd, len;
        logic [31:0] code;
        if (cur_mode == MODE_LETTERS) begin
            if (it.symbol >= hcb_pkg::CHAR_A && it.symbol <= hcb_pkg::CHAR_Z)
                if (letter_cnt[it.symbol - hcb_pkg::CHAR_A] != 16'hffff)
                    letter_cnt[it.symbol - hcb_pkg::CHAR_A]++;
        end else if (n_leaves < NLEAF) begin
            leaf_sym[n_leaves] = it.symbol;
            node_w[n_leaves]   = 22'(it.leaf_weight);
            n_leaves++;
        end else begin
            dropped = 1;
        end
        if (!it.last) return;
        if (cur_mode == MODE_LETTERS) begin
            n_leaves = 0;
            for (int i = 0; i < hcb_pkg::LETTERS; i++) begin
                if (letter_cnt[i] == 0) continue;
                if (n_leaves < NLEAF) begin
                    leaf_sym[n_leaves] = hcb_pkg::CHAR_A + 8'(i);
                    node_w[n_leaves]   = 22'(letter_cnt[i]);
                    n_leaves++;
                end else begin
                    dropped = 1;
                end
            end
        end
        if (n_leaves == 0) begin
            r = '0;
            r.no_leaves  = 1'b1;
            r.final_code = 1'b1;
            code_q.push_back(r);
            clear_run();
            return;
        end
        for (int k = 0; k < NNODE; k++) begin
            node_used[k] = 0;
            node_up[k]   = 0;
            node_left[k] = 0;
        end
        for (int k = n_leaves; k + 1 < 2 * n_leaves; k++) begin
            a = lightest(k, NNODE);
            b = lightest(k, a);
            node_up[a] = k; node_up[b] = k;
            node_used[a] = 1; node_used[b] = 1;
            node_left[k] = a;
            node_w[k] = node_w[a] + node_w[b];
        end
        // Walk leaf to root, bit 0 for the left child
        for (int i = 0; i < n_leaves; i++) begin
            code = '0;
            len  = 0;
            nd   = i;
            while (node_used[nd]) begin
                if (node_left[node_up[nd]] != nd && len < 32) code[len] = 1'b1;
                len++;
                nd = node_up[nd];
            end
            r.leaf_symbol = leaf_sym[i];
            r.code_bits   = code;
            r.code_length = 5'(len);
            r.no_leaves   = 1'b0;
            r.overflowed  = dropped;
            r.final_code  = (i + 1 == n_leaves);
            code_q.push_back(r);
        end
        clear_run();
    endtask

    task automatic add_item(logic [7:0] s, logic [15:0] w, logic l);
        hcb_pkg::t_item it;
        it.symbol = s; it.leaf_weight = w; it.last = l;
        item_q.push_back(it);
    endtask

    // One load run; pairs mode uses n random pairs, letters mode mostly letters
    task automatic add_run(logic mode, int n);
        logic [7:0] s;
        for (int i = 0; i < n; i++) begin
            if (mode == MODE_LETTERS && $urandom_range(0, 9) != 0)
                s = hcb_pkg::CHAR_A + 8'($urandom_range(0, 25));
            else
                s = 8'($urandom);
            add_item(s, $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 3)) : 16'($urandom),
                     i == n - 1);
        end
    endtask

    // Driver: bursts with random gaps, changes at falling edge
    int gap;
    always @(negedge i_clk) begin
        if (!i_rst_n || item_q.size() == 0) begin
            start <= 1'b0;
        end else if (start && busy) begin
            start <= 1'b1;
        end else if (gap > 0) begin
            gap--;
            start <= 1'b0;
        end else begin
            start  <= 1'b1;
            i_item <= item_q[0];
            if ($urandom_range(0, 5) == 0) gap = $urandom_range(1, 6);
        end
    end

    // Monitor: accept input and result transactions at rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (idle_cycles > WDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
            idle_cycles = idle_cycles + 1;
            if (start && !busy) begin
                predict_codes(i_item);
                void'(item_q.pop_front());
                idle_cycles = 0;
            end
            if (o_result_valid) begin
                idle_cycles = 0;
                if (code_q.size() == 0) begin
                    failed = 1;
                    if (mismatches < 10) $display("unexpected result %p", o_result);
                    mismatches++;
                end else if (o_result !== code_q[0]) begin
                    failed = 1;
                    if (mismatches < 10)
                        $display("mismatch: expected %p actual %p", code_q[0], o_result);
                    mismatches++;
                    void'(code_q.pop_front());
                end else begin
                    void'(code_q.pop_front());
                end
            end
        end
    end

    task automatic drain();
        while (item_q.size() != 0 || code_q.size() != 0 || start) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_mode(logic m);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_mode = m;
    endtask

    initial begin
        i_rst_n = 0; i_cfg_we = 0; i_cfg_wdata = 0; start = 0; i_item = '0;
        gap = 0; mismatches = 0; failed = 0; idle_cycles = 0;
        cur_mode = MODE_LETTERS;
        clear_run();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed letters: empty run, a and z, nonletters, single leaf
        add_item(8'h41, 16'h0, 1'b1);
        add_item(hcb_pkg::CHAR_A, 16'hffff, 1'b0);
        add_item(hcb_pkg::CHAR_Z, 16'h0, 1'b0);
        add_item(8'h60, 16'h0, 1'b0);
        add_item(8'h7b, 16'h0, 1'b0);
        add_item(hcb_pkg::CHAR_Z, 16'h0, 1'b1);
        add_item(8'h6d, 16'h0, 1'b1);
        drain();
        // Directed pairs: empty-ish, zero weights, overflow
        write_mode(MODE_PAIRS);
        add_item(8'hff, 16'h0, 1'b1);
        add_item(8'h00, 16'hffff, 1'b0);
        add_item(8'h80, 16'h0, 1'b0);
        add_item(8'h7f, 16'h0, 1'b1);
        drain();
        add_run(MODE_PAIRS, NLEAF + 3);
        drain();
        // Mode change mid-run: letters loaded, then last item under pairs
        write_mode(MODE_LETTERS);
        add_item(hcb_pkg::CHAR_A, 16'h5, 1'b0);
        drain();
        write_mode(MODE_PAIRS);
        add_item(8'h33, 16'h9, 1'b1);
        drain();

        // Random runs across both modes; mode written only when idle
        for (int r = 0; r < 20; r++) begin
            drain();
            write_mode(logic'($urandom_range(0, 1)));
            add_run(cur_mode, $urandom_range(1, 10));
        end
        drain();

        if (!failed) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
